@@ rtl/core/remote_frame_receiver_defines.svh @@
// Assertion macros for the remote frame receiver parser.
`ifndef REMOTE_FRAME_RECEIVER_DEFINES_SVH
`define REMOTE_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTH
`define RFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("remote frame receiver check failed");
`define RFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("remote frame receiver check failed");
`else
`define RFR_ASSERT(label, prop)
`define RFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/rfr_pkg.sv @@
// Types, constants and the CRC function of the remote frame receiver.
`default_nettype none
package rfr_pkg;

    localparam int STICK_FRAME_LEN = 12;
    localparam int MODE_FRAME_LEN  = 6;
    localparam int POS_W           = 4;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;
    localparam int OUT_DATA_W      = 176;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 4'd1;
    localparam logic [POS_W-1:0] POS_SEQ    = 4'd2;

    localparam logic [1:0] REG_FIRST_SYNC = 2'd0;
    localparam logic [1:0] REG_STICK_SYNC = 2'd1;
    localparam logic [1:0] REG_MODE_SYNC  = 2'd2;

    localparam logic [7:0] FIRST_SYNC_RESET = 8'd170;
    localparam logic [7:0] STICK_SYNC_RESET = 8'd85;
    localparam logic [7:0] MODE_SYNC_RESET  = 8'd86;

    localparam logic KIND_STICK = 1'b0;
    localparam logic KIND_MODE  = 1'b1;

    typedef struct packed {
        logic [7:0] first_sync;
        logic [7:0] stick_sync;
        logic [7:0] mode_sync;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               frame_kind;
        logic               crc_good;
        logic [7:0]         sequence_number;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [7:0]         button_flags;
        logic [7:0]         mode_value;
        logic [31:0]        good_frames;
        logic [31:0]        crc_errors;
        logic [31:0]        lost_frames;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/remote_frame_receiver.sv @@
// Top level of the remote frame receiver: input stage, parser, result register, APB registers.
// A frame's last byte is registered in the input stage, its result word then in the result
// register (m_tvalid). Throughput: one byte per cycle, set by the parser's combinational
// CRC update, while no result waits on m_tready; the input stage still takes a byte then.
// Reset clears the frame hunt, counters, held fields and result valid; sync registers
// return to 0xAA, 0x55 and 0x56.
`default_nettype none
module remote_frame_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // crc_good, sequence_number, axis_x, axis_y, axis_z, button_flags, mode_value,
    // good_frames, crc_errors, lost_frames, then zero padding.
    output logic [rfr_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser,  // frame_kind
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rfr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rfr_pkg::DATA_W-1:0]    pwdata,
    output logic      [rfr_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);
    import rfr_pkg::*;

    cfg_t        cfg;
    result_t     res;
    result_t     out_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    rfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = advance && res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (advance && res.valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.frame_kind;
    assign m_tdata  = {7'd0,
                       out_reg.lost_frames,
                       out_reg.crc_errors,
                       out_reg.good_frames,
                       out_reg.mode_value,
                       out_reg.button_flags,
                       out_reg.axis_z,
                       out_reg.axis_y,
                       out_reg.axis_x,
                       out_reg.sequence_number,
                       out_reg.crc_good};

endmodule
`default_nettype wire

@@ rtl/core/rfr_cfg.sv @@
// APB register bank holding the three sync byte registers.
`default_nettype none
module rfr_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rfr_pkg::DATA_W-1:0] pwdata,
    output logic      [rfr_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output rfr_pkg::cfg_t                  cfg
);
    import rfr_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_FIRST_SYNC: cfg_next.first_sync = pwdata[7:0];
                REG_STICK_SYNC: cfg_next.stick_sync = pwdata[7:0];
                REG_MODE_SYNC:  cfg_next.mode_sync  = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FIRST_SYNC: prdata = {24'd0, cfg_reg.first_sync};
            REG_STICK_SYNC: prdata = {24'd0, cfg_reg.stick_sync};
            REG_MODE_SYNC:  prdata = {24'd0, cfg_reg.mode_sync};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync <= FIRST_SYNC_RESET;
            cfg_reg.stick_sync <= STICK_SYNC_RESET;
            cfg_reg.mode_sync  <= MODE_SYNC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rfr_parser.sv @@
// Frame parser: sync hunt, running CRC, frame check, held fields and counters.
`default_nettype none
`include "remote_frame_receiver_defines.svh"
module rfr_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rfr_pkg::cfg_t   cfg,
    input  wire logic            fire,
    input  wire logic [7:0]      rx_byte,
    output rfr_pkg::result_t     res
);
    import rfr_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               kind_reg, kind_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         seq_reg, seq_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic signed [15:0] z_reg, z_next;
    logic [7:0]         flags_reg, flags_next;
    logic [7:0]         mode_reg, mode_next;
    logic [31:0]        good_reg, good_next;
    logic [31:0]        err_reg, err_next;
    logic [31:0]        lost_reg, lost_next;
    logic [7:0]         frame_reg [STICK_FRAME_LEN];

    logic [POS_W-1:0]   frame_len;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   crc_lo_pos;
    logic [15:0]        rx_crc;
    logic               crc_ok;
    logic               in_body;
    logic               frame_done;
    logic [7:0]         seq_gap;

    assign frame_len  = kind_reg ? POS_W'(MODE_FRAME_LEN) : POS_W'(STICK_FRAME_LEN);
    assign crc_lo_pos = frame_len - POS_W'(2);
    assign pos_inc    = pos_reg + POS_W'(1);
    assign in_body    = (pos_reg >= POS_SEQ) && (pos_reg < POS_W'(STICK_FRAME_LEN));
    assign frame_done = in_body && (pos_inc >= frame_len);
    assign rx_crc     = {rx_byte, frame_reg[crc_lo_pos]};
    assign crc_ok     = (rx_crc == crc_reg);
    assign seq_gap    = frame_reg[2] - seq_reg - 8'd1;

    always_comb
    begin
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        crc_next   = crc_reg;
        seq_next   = seq_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flags_next = flags_reg;
        mode_next  = mode_reg;
        good_next  = good_reg;
        err_next   = err_reg;
        lost_next  = lost_reg;
        if (fire)
        begin
            priority if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == cfg.first_sync)
                begin
                    pos_next = POS_SECOND;
                    crc_next = crc16_update(CRC_INIT, rx_byte);
                end
            end
            else if (pos_reg == POS_SECOND)
            begin
                priority if (rx_byte == cfg.stick_sync)
                begin
                    kind_next = KIND_STICK;
                    pos_next  = POS_SEQ;
                    crc_next  = crc16_update(crc_reg, rx_byte);
                end
                else if (rx_byte == cfg.mode_sync)
                begin
                    kind_next = KIND_MODE;
                    pos_next  = POS_SEQ;
                    crc_next  = crc16_update(crc_reg, rx_byte);
                end
                else if (rx_byte == cfg.first_sync)
                begin
                    crc_next = crc16_update(CRC_INIT, rx_byte);
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (!in_body)
            begin
                pos_next = POS_HUNT;
            end
            else if (!frame_done)
            begin
                pos_next = pos_inc;
                if (pos_reg < crc_lo_pos)
                    crc_next = crc16_update(crc_reg, rx_byte);
            end
            else
            begin
                pos_next = POS_HUNT;
                if (!crc_ok)
                begin
                    err_next = err_reg + 32'd1;
                end
                else
                begin
                    good_next = good_reg + 32'd1;
                    if (kind_reg == KIND_STICK)
                    begin
                        if (good_reg != 32'd0)
                            lost_next = lost_reg + {24'd0, seq_gap};
                        seq_next   = frame_reg[2];
                        x_next     = {frame_reg[4], frame_reg[3]};
                        y_next     = {frame_reg[6], frame_reg[5]};
                        z_next     = {frame_reg[8], frame_reg[7]};
                        flags_next = frame_reg[9];
                    end
                    else
                    begin
                        mode_next = frame_reg[3];
                    end
                end
            end
        end
    end

    always_comb
    begin
        res.valid           = fire && frame_done;
        res.frame_kind      = kind_reg;
        res.crc_good        = crc_ok;
        res.sequence_number = seq_next;
        res.axis_x          = x_next;
        res.axis_y          = y_next;
        res.axis_z          = z_next;
        res.button_flags    = flags_next;
        res.mode_value      = mode_next;
        res.good_frames     = good_next;
        res.crc_errors      = err_next;
        res.lost_frames     = lost_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_body)
            frame_reg[pos_reg] <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_HUNT;
            kind_reg  <= KIND_STICK;
            crc_reg   <= CRC_INIT;
            seq_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            flags_reg <= '0;
            mode_reg  <= '0;
            good_reg  <= '0;
            err_reg   <= '0;
            lost_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            crc_reg   <= crc_next;
            seq_reg   <= seq_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= flags_next;
            mode_reg  <= mode_next;
            good_reg  <= good_next;
            err_reg   <= err_next;
            lost_reg  <= lost_next;
        end
    end

    `RFR_ASSERT(a_pos_range, pos_reg < POS_W'(STICK_FRAME_LEN))
    `RFR_ASSERT(a_done_at_last_byte, res.valid |-> ((kind_reg == KIND_STICK && pos_reg == POS_W'(STICK_FRAME_LEN - 1)) || (kind_reg == KIND_MODE && pos_reg == POS_W'(MODE_FRAME_LEN - 1))))
    `RFR_ASSERT_NEXT(a_good_counts, res.valid && crc_ok, good_reg == $past(good_reg) + 32'd1 && err_reg == $past(err_reg))
    `RFR_ASSERT_NEXT(a_bad_counts, res.valid && !crc_ok, err_reg == $past(err_reg) + 32'd1 && good_reg == $past(good_reg) && lost_reg == $past(lost_reg))
    `RFR_ASSERT_NEXT(a_idle_holds, !fire, $stable(pos_reg) && $stable(good_reg) && $stable(err_reg))

endmodule
`default_nettype wire

@@ verif/remote_frame_receiver_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the remote frame receiver: directed frames, then random byte streams.
module remote_frame_receiver_tb;
    import rfr_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] REG_SPARE   = 2'd3;

    // One result word as it leaves the block, padding in the top bits, frame kind at the bottom.
    typedef struct packed {
        logic [6:0]         pad;
        logic [31:0]        lost_frames;
        logic [31:0]        crc_errors;
        logic [31:0]        good_frames;
        logic [7:0]         mode_value;
        logic [7:0]         button_flags;
        logic signed [15:0] axis_z;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_x;
        logic [7:0]         sequence_number;
        logic               crc_good;
        logic               frame_kind;
    } frame_result_t;

    // Lead bytes go out before the frame, the first of them in the lowest byte.
    typedef struct packed {
        logic [1:0]      n_lead;
        logic [2:0][7:0] lead;
        logic            kind;
        logic [7:0]      third;
        logic [15:0]     x;
        logic [15:0]     y;
        logic [15:0]     z;
        logic [7:0]      flags;
        logic [7:0]      mode;
        logic [15:0]     crc_flip;
        logic            typed;
        frame_result_t   want;
    } frame_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    cfg_t               sync_regs;
    int unsigned        rx_position;
    logic               rx_kind;
    logic [7:0]         rx_stored [STICK_FRAME_LEN];
    logic [7:0]         last_seq;
    logic [31:0]        good_total;
    logic [31:0]        error_total;
    logic [31:0]        lost_total;
    logic signed [15:0] held_x;
    logic signed [15:0] held_y;
    logic signed [15:0] held_z;
    logic [7:0]         held_flags;
    logic [7:0]         held_mode;

    frame_result_t awaited_frames [$];
    int            field_mismatches = 0;
    int            frames_seen      = 0;
    int            phase_bytes      = 0;
    int            ready_stall      = 0;
    int            cycle_count      = 0;
    bit            calm             = 1'b0;

    frame_row_t frame_rows [5] = '{
        '{2'd1, {16'h0000, 8'h00}, KIND_MODE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          8'h7E, 16'h0001, 1'b1,
          '{7'd0, 32'd0, 32'd1, 32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00,
            1'b0, KIND_MODE}},
        '{2'd1, {16'h0000, FIRST_SYNC_RESET}, KIND_STICK, 8'h00, 16'h8000, 16'h7FFF, 16'hFFFF,
          8'hFF, 8'h00, 16'h0000, 1'b1,
          '{7'd0, 32'd0, 32'd1, 32'd1, 8'h00, 8'hFF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'h00,
            1'b1, KIND_STICK}},
        '{2'd0, 24'h000000, KIND_MODE, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          8'hFF, 16'h0000, 1'b1,
          '{7'd0, 32'd0, 32'd1, 32'd2, 8'hFF, 8'hFF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'h00,
            1'b1, KIND_MODE}},
        '{2'd2, {8'h00, 8'h00, FIRST_SYNC_RESET}, KIND_STICK, 8'hFF, 16'h0001, 16'hFFFE,
          16'h0000, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
        '{2'd0, 24'h000000, KIND_STICK, 8'h00, 16'h1234, 16'h8001, 16'h7FFE, 8'h5A,
          8'h00, 16'h8000, 1'b0, '0}
    };

    remote_frame_receiver u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_cycles();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] ccitt_crc(input logic [7:0] bytes_in [STICK_FRAME_LEN],
                                              input int count);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < count; i++)
        begin
            crc = crc ^ {bytes_in[i], 8'h00};
            for (int b = 0; b < 8; b++)
            begin
                if (crc[15])
                    crc = {crc[14:0], 1'b0} ^ CRC_POLY;
                else
                    crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Advances the frame parser by one received byte; returns 1 when a frame completes.
    function automatic bit parse_rx_byte(input logic [7:0] c, output frame_result_t r);
        int unsigned frame_len;
        logic [7:0]  seq_gap;
        logic [15:0] rx_crc;
        logic        crc_ok;
        r = '0;
        if (rx_position == 0)
        begin
            if (c == sync_regs.first_sync)
            begin
                rx_stored[0] = c;
                rx_position = 1;
            end
            return 1'b0;
        end
        if (rx_position == 1)
        begin
            if (c == sync_regs.stick_sync)
            begin
                rx_stored[1] = c;
                rx_kind = KIND_STICK;
                rx_position = 2;
            end
            else if (c == sync_regs.mode_sync)
            begin
                rx_stored[1] = c;
                rx_kind = KIND_MODE;
                rx_position = 2;
            end
            else if (c == sync_regs.first_sync)
                rx_stored[0] = c;
            else
                rx_position = 0;
            return 1'b0;
        end
        rx_stored[rx_position] = c;
        rx_position++;
        frame_len = (rx_kind == KIND_MODE) ? MODE_FRAME_LEN : STICK_FRAME_LEN;
        if (rx_position < frame_len)
            return 1'b0;
        rx_position = 0;
        rx_crc = {rx_stored[frame_len-1], rx_stored[frame_len-2]};
        crc_ok = (ccitt_crc(rx_stored, frame_len - 2) == rx_crc);
        if (!crc_ok)
            error_total++;
        else
        begin
            if (rx_kind == KIND_STICK)
            begin
                if (good_total != 0)
                begin
                    seq_gap = rx_stored[2] - last_seq - 8'd1;
                    lost_total += 32'(seq_gap);
                end
                last_seq = rx_stored[2];
                held_x = {rx_stored[4], rx_stored[3]};
                held_y = {rx_stored[6], rx_stored[5]};
                held_z = {rx_stored[8], rx_stored[7]};
                held_flags = rx_stored[9];
            end
            else
                held_mode = rx_stored[3];
            good_total++;
        end
        r.frame_kind = rx_kind;
        r.crc_good = crc_ok;
        r.sequence_number = last_seq;
        r.axis_x = held_x;
        r.axis_y = held_y;
        r.axis_z = held_z;
        r.button_flags = held_flags;
        r.mode_value = held_mode;
        r.good_frames = good_total;
        r.crc_errors = error_total;
        r.lost_frames = lost_total;
        return 1'b1;
    endfunction

    function automatic void build_frame(ref logic [7:0] q [$], input logic kind,
                                        input logic [7:0] third, input logic [15:0] x,
                                        input logic [15:0] y, input logic [15:0] z,
                                        input logic [7:0] flags, input logic [7:0] mode,
                                        input logic [15:0] crc_flip);
        logic [7:0]  f [STICK_FRAME_LEN];
        int          len;
        logic [15:0] crc;
        f = '{default: 8'h00};
        len = (kind == KIND_MODE) ? MODE_FRAME_LEN : STICK_FRAME_LEN;
        f[0] = sync_regs.first_sync;
        f[1] = (kind == KIND_MODE) ? sync_regs.mode_sync : sync_regs.stick_sync;
        f[2] = third;
        if (kind == KIND_MODE)
            f[3] = mode;
        else
        begin
            f[3] = x[7:0];
            f[4] = x[15:8];
            f[5] = y[7:0];
            f[6] = y[15:8];
            f[7] = z[7:0];
            f[8] = z[15:8];
            f[9] = flags;
        end
        crc = ccitt_crc(f, len - 2) ^ crc_flip;
        f[len-2] = crc[7:0];
        f[len-1] = crc[15:8];
        q.delete();
        for (int i = 0; i < len; i++)
            q.push_back(f[i]);
    endfunction

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            field_mismatches++;
            if (field_mismatches <= 10)
                $display("result word %0d: %s expected %h, got %h",
                         frames_seen, field, want, got);
        end
    endfunction

    task automatic send_rx_byte(input logic [7:0] value, input logic typed = 1'b0,
                                input frame_result_t want = '0);
        frame_result_t predicted;
        int            gap;
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do @(posedge clk); while (!s_tready);
        if (parse_rx_byte(value, predicted))
            awaited_frames.push_back(typed ? want : predicted);
        phase_bytes++;
        gap = idle_cycles();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] q [$], input logic typed,
                              input frame_result_t want);
        for (int i = 0; i < q.size(); i++)
            send_rx_byte(q[i], typed && (i == q.size() - 1), want);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_FIRST_SYNC: sync_regs.first_sync = value;
            REG_STICK_SYNC: sync_regs.stick_sync = value;
            REG_MODE_SYNC:  sync_regs.mode_sync = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [1:0] index, input logic [7:0] want,
                                  input string name);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        compare_field(name, 32'(want), 32'(prdata[7:0]));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_sync_regs();
        apb_read_check(REG_FIRST_SYNC, sync_regs.first_sync, "first_sync register");
        apb_read_check(REG_STICK_SYNC, sync_regs.stick_sync, "stick_sync register");
        apb_read_check(REG_MODE_SYNC, sync_regs.mode_sync, "mode_sync register");
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (awaited_frames.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_sync_regs(input logic [7:0] first_val, input logic [7:0] stick_val,
                                 input logic [7:0] mode_val);
        drain_results();
        // A byte that completes no frame may still sit in the input stage or the parser.
        repeat (4) @(posedge clk);
        apb_write(REG_FIRST_SYNC, first_val);
        apb_write(REG_STICK_SYNC, stick_val);
        apb_write(REG_MODE_SYNC, mode_val);
        apb_write(REG_SPARE, 8'($urandom));
        read_sync_regs();
    endtask

    task automatic random_phase(input int quota);
        logic [7:0] frame_q [$];
        int         pick;
        logic       kind;
        logic [7:0] third;
        logic [15:0] flip;
        phase_bytes = 0;
        while (phase_bytes < quota)
        begin
            if ($urandom_range(0, 9) == 0)
                calm = !calm;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                kind = ($urandom_range(0, 2) == 0) ? KIND_MODE : KIND_STICK;
                third = ($urandom_range(0, 3) == 0) ? 8'($urandom) : last_seq + 8'd1;
                flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
                build_frame(frame_q, kind, third, 16'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom), 8'($urandom), flip);
                send_frame(frame_q, 1'b0, '0);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom));
            end
            else
            begin
                send_rx_byte(sync_regs.first_sync);
                if ($urandom_range(0, 1) == 1)
                    send_rx_byte(sync_regs.first_sync);
                send_rx_byte(8'($urandom));
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_result_t got_frame;
        frame_result_t want_frame;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_frame = frame_result_t'({m_tdata, m_tuser});
                if (awaited_frames.size() == 0)
                begin
                    field_mismatches++;
                    if (field_mismatches <= 10)
                        $display("result word %0d arrived with nothing expected", frames_seen);
                end
                else
                begin
                    want_frame = awaited_frames.pop_front();
                    compare_field("frame_kind", 32'(want_frame.frame_kind),
                                  32'(got_frame.frame_kind));
                    compare_field("crc_good", 32'(want_frame.crc_good),
                                  32'(got_frame.crc_good));
                    compare_field("sequence_number", 32'(want_frame.sequence_number),
                                  32'(got_frame.sequence_number));
                    compare_field("axis_x", 32'(want_frame.axis_x), 32'(got_frame.axis_x));
                    compare_field("axis_y", 32'(want_frame.axis_y), 32'(got_frame.axis_y));
                    compare_field("axis_z", 32'(want_frame.axis_z), 32'(got_frame.axis_z));
                    compare_field("button_flags", 32'(want_frame.button_flags),
                                  32'(got_frame.button_flags));
                    compare_field("mode_value", 32'(want_frame.mode_value),
                                  32'(got_frame.mode_value));
                    compare_field("good_frames", want_frame.good_frames, got_frame.good_frames);
                    compare_field("crc_errors", want_frame.crc_errors, got_frame.crc_errors);
                    compare_field("lost_frames", want_frame.lost_frames, got_frame.lost_frames);
                    compare_field("padding", 32'd0, 32'(got_frame.pad));
                end
                frames_seen++;
            end
            if (ready_stall > 0)
            begin
                ready_stall--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                ready_stall = idle_cycles();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] frame_q [$];
        sync_regs = '{FIRST_SYNC_RESET, STICK_SYNC_RESET, MODE_SYNC_RESET};
        rx_position = 0;
        rx_kind = KIND_STICK;
        rx_stored = '{default: 8'h00};
        last_seq = 8'h00;
        good_total = '0;
        error_total = '0;
        lost_total = '0;
        held_x = '0;
        held_y = '0;
        held_z = '0;
        held_flags = 8'h00;
        held_mode = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_sync_regs();

        foreach (frame_rows[i])
        begin
            for (int j = 0; j < frame_rows[i].n_lead; j++)
                send_rx_byte(frame_rows[i].lead[j]);
            build_frame(frame_q, frame_rows[i].kind, frame_rows[i].third, frame_rows[i].x,
                        frame_rows[i].y, frame_rows[i].z, frame_rows[i].flags,
                        frame_rows[i].mode, frame_rows[i].crc_flip);
            send_frame(frame_q, frame_rows[i].typed, frame_rows[i].want);
        end

        random_phase(95);
        // With mode equal to first, a second byte of that value must open a mode frame.
        set_sync_regs(8'h00, 8'hFF, 8'h00);
        random_phase(75);
        // With stick equal to mode, the stick kind takes precedence.
        set_sync_regs(8'hFF, 8'h00, 8'h00);
        random_phase(75);
        set_sync_regs(8'($urandom), 8'($urandom), 8'($urandom));
        random_phase(75);
        set_sync_regs(8'h5A, 8'h5A, 8'hA5);
        random_phase(60);

        drain_results();
        repeat (8) @(posedge clk);
        if (field_mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
